### design/mi3_pkg.sv
// Package for the 3x3 matrix inverse unit.
// Holds the cofactor operand map, element count and the sign/singular flag type.
// No dependencies.
`default_nettype none

package mi3_pkg;

  localparam int N_ELEM = 9;

  typedef logic [3:0] elem_idx_t;

  // Cofactor i = a[P] * a[Q] - a[S] * a[T], listed as {P, Q, S, T}, row-major adjugate order.
  localparam elem_idx_t COF_IDX [N_ELEM][4] = '{
    '{4'd4, 4'd8, 4'd5, 4'd7},
    '{4'd2, 4'd7, 4'd1, 4'd8},
    '{4'd1, 4'd5, 4'd2, 4'd4},
    '{4'd5, 4'd6, 4'd3, 4'd8},
    '{4'd0, 4'd8, 4'd2, 4'd6},
    '{4'd2, 4'd3, 4'd0, 4'd5},
    '{4'd3, 4'd7, 4'd4, 4'd6},
    '{4'd1, 4'd6, 4'd0, 4'd7},
    '{4'd0, 4'd4, 4'd1, 4'd3}
  };

  // Determinant expands along row one: a11*C0 + a12*C3 + a13*C6.
  localparam elem_idx_t DET_COF [3] = '{4'd0, 4'd3, 4'd6};

  typedef struct packed {
    logic neg;
    logic sing;
  } mi3_flags_t;

endpackage

`default_nettype wire

### design/matrix_inverse_3x3_unit.sv
// 3x3 matrix inverse by adjugate and exact determinant, fully pipelined.
// Throughput: one matrix per cycle; the divider spends one stage per quotient bit.
// Reset: synchronous rst clears the valid pipeline; busy is high only during reset.
// Receiver cannot stall; each result shows for one cycle with done.
// Depends on mi3_pkg and mi3_div.
`default_nettype none

module matrix_inverse_3x3_unit
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic signed [ELEM_WIDTH-1:0] a11,
  input  wire logic signed [ELEM_WIDTH-1:0] a12,
  input  wire logic signed [ELEM_WIDTH-1:0] a13,
  input  wire logic signed [ELEM_WIDTH-1:0] a21,
  input  wire logic signed [ELEM_WIDTH-1:0] a22,
  input  wire logic signed [ELEM_WIDTH-1:0] a23,
  input  wire logic signed [ELEM_WIDTH-1:0] a31,
  input  wire logic signed [ELEM_WIDTH-1:0] a32,
  input  wire logic signed [ELEM_WIDTH-1:0] a33,
  output logic                              done,
  output logic signed [ELEM_WIDTH-1:0]      inv11,
  output logic signed [ELEM_WIDTH-1:0]      inv12,
  output logic signed [ELEM_WIDTH-1:0]      inv13,
  output logic signed [ELEM_WIDTH-1:0]      inv21,
  output logic signed [ELEM_WIDTH-1:0]      inv22,
  output logic signed [ELEM_WIDTH-1:0]      inv23,
  output logic signed [ELEM_WIDTH-1:0]      inv31,
  output logic signed [ELEM_WIDTH-1:0]      inv32,
  output logic signed [ELEM_WIDTH-1:0]      inv33,
  output logic                              singular
);

  localparam int E   = ELEM_WIDTH;
  localparam int CW  = 2*ELEM_WIDTH + 1;
  localparam int DW  = 3*ELEM_WIDTH + 1;
  localparam int DMW = 3*ELEM_WIDTH;
  localparam int NMW = 2*ELEM_WIDTH + 2*FRAC_BITS;
  localparam int LAT = 7 + ELEM_WIDTH + 3;

  logic [LAT-1:0] vld;

  logic signed [E-1:0]    a_in [N_ELEM];
  logic signed [E-1:0]    a1   [N_ELEM];
  logic signed [E-1:0]    a2r  [3];
  logic signed [E-1:0]    a3r  [3];
  logic signed [2*E-1:0]  px   [N_ELEM];
  logic signed [2*E-1:0]  py   [N_ELEM];
  logic signed [CW-1:0]   cf3  [N_ELEM];
  logic signed [CW-1:0]   cf4  [N_ELEM];
  logic signed [CW-1:0]   cf5  [N_ELEM];
  logic signed [CW-1:0]   cf6  [N_ELEM];
  logic signed [2*E:0]    lo4  [3];
  logic signed [2*E:0]    hi4  [3];
  logic signed [DW-1:0]   t5   [3];
  logic signed [DW-1:0]   det6;

  logic [NMW-1:0]         nm7  [N_ELEM];
  logic [DMW-1:0]         dm7;
  mi3_flags_t             flg7 [N_ELEM];
  logic signed [E-1:0]    quo  [N_ELEM];
  mi3_flags_t             fout [N_ELEM];

  assign busy = rst;

  always_comb begin
    a_in[0] = a11; a_in[1] = a12; a_in[2] = a13;
    a_in[3] = a21; a_in[4] = a22; a_in[5] = a23;
    a_in[6] = a31; a_in[7] = a32; a_in[8] = a33;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[LAT-2:0], start & ~busy};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < N_ELEM; i++) begin
      a1[i]  <= a_in[i];
      px[i]  <= a1[COF_IDX[i][0]] * a1[COF_IDX[i][1]];
      py[i]  <= a1[COF_IDX[i][2]] * a1[COF_IDX[i][3]];
      cf3[i] <= CW'(px[i]) - CW'(py[i]);
      cf4[i] <= cf3[i];
      cf5[i] <= cf4[i];
      cf6[i] <= cf5[i];
    end
    for (int k = 0; k < 3; k++) begin
      a2r[k] <= a1[k];
      a3r[k] <= a2r[k];
      lo4[k] <= a3r[k] * $signed({1'b0, cf3[DET_COF[k]][E-1:0]});
      hi4[k] <= a3r[k] * $signed(cf3[DET_COF[k]][CW-1:E]);
      t5[k]  <= (DW'(hi4[k]) <<< E) + DW'(lo4[k]);
    end
    det6 <= t5[0] + t5[1] + t5[2];
  end

  logic           det_neg;
  logic           det_zero;
  logic [DW-1:0]  det_abs;
  logic [CW-1:0]  cf_abs [N_ELEM];

  always_comb begin
    det_neg  = det6[DW-1];
    det_zero = (det6 == '0);
    det_abs  = det_neg ? DW'(-det6) : DW'(det6);
    for (int i = 0; i < N_ELEM; i++) begin
      cf_abs[i] = cf6[i][CW-1] ? CW'(-cf6[i]) : CW'(cf6[i]);
    end
  end

  always_ff @(posedge clk) begin
    dm7 <= det_abs[DMW-1:0];
    for (int i = 0; i < N_ELEM; i++) begin
      nm7[i]       <= NMW'(cf_abs[i][2*E-1:0]) << (2*FRAC_BITS);
      flg7[i].neg  <= cf6[i][CW-1] ^ det_neg;
      flg7[i].sing <= det_zero;
    end
  end

  for (genvar i = 0; i < N_ELEM; i++) begin : g_div
    mi3_div #(
      .ELEM_WIDTH(ELEM_WIDTH),
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk    (clk),
      .nm     (nm7[i]),
      .dm     (dm7),
      .flg_in (flg7[i]),
      .quo    (quo[i]),
      .flg_out(fout[i])
    );
  end

  always_comb begin
    done     = vld[LAT-1];
    inv11    = quo[0]; inv12 = quo[1]; inv13 = quo[2];
    inv21    = quo[3]; inv22 = quo[4]; inv23 = quo[5];
    inv31    = quo[6]; inv32 = quo[7]; inv33 = quo[8];
    singular = fout[0].sing;
  end

`ifndef SYNTHESIS
  a_done_from_transfer: assert property (@(posedge clk) disable iff (rst)
    done |-> $past(start && !busy, LAT))
    else $error("result without a matching transfer");

  a_singular_zero: assert property (@(posedge clk) disable iff (rst)
    (done && singular) |-> (inv11 == '0 && inv22 == '0 && inv33 == '0 && inv12 == '0))
    else $error("singular result with nonzero elements");

  a_busy_reset_only: assert property (@(posedge clk)
    !rst |-> !busy)
    else $error("busy outside reset");
`endif

endmodule

`default_nettype wire

### design/mi3_div.sv
// Pipelined restoring divider with saturation for one inverse element.
// One quotient bit per stage; depends on mi3_pkg for the flag type.
`default_nettype none

module mi3_div
  import mi3_pkg::*;
#(
  parameter int ELEM_WIDTH = 32,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                             clk,
  input  wire logic [2*ELEM_WIDTH+2*FRAC_BITS-1:0] nm,
  input  wire logic [3*ELEM_WIDTH-1:0]          dm,
  input  wire mi3_flags_t                       flg_in,
  output logic signed [ELEM_WIDTH-1:0]          quo,
  output mi3_flags_t                            flg_out
);

  localparam int E    = ELEM_WIDTH;
  localparam int NMW  = 2*ELEM_WIDTH + 2*FRAC_BITS;
  localparam int DMW  = 3*ELEM_WIDTH;
  localparam int QB   = ELEM_WIDTH + 1;
  localparam int HW   = NMW - QB;
  localparam int CMPW = (HW > DMW) ? HW : DMW;

  logic [DMW-1:0] rem  [QB+1];
  logic [QB-1:0]  low  [QB+1];
  logic [QB-1:0]  q    [QB+1];
  logic [DMW-1:0] dmr  [QB+1];
  logic           big  [QB+1];
  mi3_flags_t     flg  [QB+1];

  logic [CMPW-1:0] hi_ext;
  logic [CMPW-1:0] dm_ext;

  always_comb begin
    hi_ext = CMPW'(nm[NMW-1:QB]);
    dm_ext = CMPW'(dm);
  end

  always_ff @(posedge clk) begin
    rem[0] <= DMW'(hi_ext);
    low[0] <= nm[QB-1:0];
    q[0]   <= '0;
    dmr[0] <= dm;
    big[0] <= (hi_ext >= dm_ext);
    flg[0] <= flg_in;
  end

  for (genvar i = 0; i < QB; i++) begin : g_stage
    logic [DMW:0] trial;
    logic [DMW:0] diff;
    logic         ge;

    always_comb begin
      trial = {rem[i], low[i][QB-1]};
      diff  = trial - {1'b0, dmr[i]};
      ge    = (trial >= {1'b0, dmr[i]});
    end

    always_ff @(posedge clk) begin
      rem[i+1] <= ge ? diff[DMW-1:0] : trial[DMW-1:0];
      low[i+1] <= {low[i][QB-2:0], 1'b0};
      q[i+1]   <= {q[i][QB-2:0], ge};
      dmr[i+1] <= dmr[i];
      big[i+1] <= big[i];
      flg[i+1] <= flg[i];
    end
  end

  localparam logic [QB-1:0] POS_LIM = QB'((QB'(1) << (E-1)) - QB'(1));
  localparam logic [QB-1:0] NEG_LIM = QB'(QB'(1) << (E-1));

  logic [QB-1:0] qf;
  logic [QB-1:0] qneg;
  logic [E-1:0]  res;

  always_comb begin
    qf   = q[QB];
    qneg = ~qf + QB'(1);
    if (flg[QB].sing) begin
      res = '0;
    end else if (flg[QB].neg) begin
      res = (big[QB] || (qf > NEG_LIM)) ? NEG_LIM[E-1:0] : qneg[E-1:0];
    end else begin
      res = (big[QB] || (qf > POS_LIM)) ? POS_LIM[E-1:0] : qf[E-1:0];
    end
  end

  always_ff @(posedge clk) begin
    quo     <= res;
    flg_out <= flg[QB];
  end

endmodule

`default_nettype wire
